FILE: hdl/hcbr_pkg.sv
// Package for the hashed counter bounded random block.
// Holds the hash constants, the mask function and the command and status structs.
// No dependencies.
package hcbr_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned Rounds  = 4;
  localparam int unsigned RoundW  = 2;

  localparam logic [DataW-1:0] MixK0 = 32'd1833778363;
  localparam logic [DataW-1:0] MixK1 = 32'd337170863;
  localparam logic [DataW-1:0] MixK2 = 32'd620363059;
  localparam logic [DataW-1:0] MixK3 = 32'd232140641;
  localparam int unsigned      MixS1 = 13;
  localparam int unsigned      MixS2 = 10;
  localparam int unsigned      MixS3 = 21;

  localparam logic [RoundW-1:0] RoundFirst = 2'd0;
  localparam logic [RoundW-1:0] RoundLast  = 2'(Rounds - 1);

  typedef struct packed {
    logic              load;
    logic              mul;
    logic              mix;
    logic              emit;
    logic [RoundW-1:0] round;
  } hcbr_cmd_t;

  typedef struct packed {
    logic trivial;
    logic draw_ok;
  } hcbr_status_t;

  function automatic logic [DataW-1:0] mix_const(input logic [RoundW-1:0] round);
    logic [DataW-1:0] k;
    case (round)
      2'd0:    k = MixK0;
      2'd1:    k = MixK1;
      2'd2:    k = MixK2;
      default: k = MixK3;
    endcase
    return k;
  endfunction

  function automatic logic [DataW-1:0] cover_mask(input logic [DataW-1:0] v);
    logic [DataW-1:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

endpackage

FILE: hdl/hcbr_dp.sv
// Datapath of the hashed counter bounded random block: seed, draw counter,
// shared multiplier, hash accumulator, mask and output value register.
// Depends on hcbr_pkg.
module hcbr_dp
  import hcbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic [DataW-1:0]   sides_i,
  input  hcbr_cmd_t          cmd_i,
  output hcbr_status_t       status_o,
  output logic [DataW-1:0]   value_o
);

  logic [DataW-1:0] seed_q, seed_d;
  logic [DataW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] sides_q, mask_q;
  logic [DataW-1:0] acc_q, prod_q, value_q;
  logic [DataW-1:0] cnt_inc, mul_op, mix_term, draw;

  assign cnt_inc = cnt_q + 32'd1;
  assign mul_op  = (cmd_i.round == RoundFirst) ? cnt_inc : acc_q;
  assign draw    = acc_q & mask_q;

  always_comb begin
    case (cmd_i.round)
      2'd0:    mix_term = seed_q;
      2'd1:    mix_term = (acc_q >> MixS1) ^ acc_q;
      2'd2:    mix_term = acc_q >> MixS2;
      default: mix_term = acc_q >> MixS3;
    endcase
  end

  assign seed_d = cfg_we_i ? cfg_wdata_i : seed_q;
  assign cnt_d  = (cmd_i.mul && cmd_i.round == RoundFirst) ? cnt_inc : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      cnt_q  <= '0;
    end else begin
      seed_q <= seed_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sides_q <= sides_i;
      mask_q  <= cover_mask(sides_i - 32'd1);
    end
    if (cmd_i.mul) begin
      prod_q <= mul_op * mix_const(cmd_i.round);
    end
    if (cmd_i.mix) begin
      acc_q <= prod_q ^ mix_term;
    end
    if (cmd_i.emit) begin
      value_q <= status_o.trivial ? '0 : draw;
    end
  end

  assign status_o.trivial = (sides_q <= 32'd1);
  assign status_o.draw_ok = (draw < sides_q);
  assign value_o          = value_q;

endmodule

FILE: hdl/hcbr_ctrl.sv
// Controller of the hashed counter bounded random block: sequences the hash
// rounds, the rejection test and the output handshake.
// Depends on hcbr_pkg.
module hcbr_ctrl
  import hcbr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  hcbr_status_t status_i,
  output hcbr_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StMul,
    StMix,
    StTest,
    StDone
  } state_e;

  state_e            state_q, state_d;
  logic [RoundW-1:0] round_q, round_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    round_d   = round_q;
    cmd_o     = '0;
    cmd_o.round = round_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StStart;
        end
      end
      StStart: begin
        round_d = RoundFirst;
        state_d = status_i.trivial ? StDone : StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StMix;
      end
      StMix: begin
        cmd_o.mix = 1'b1;
        if (round_q == RoundLast) begin
          state_d = StTest;
        end else begin
          round_d = round_q + 2'd1;
          state_d = StMul;
        end
      end
      StTest: begin
        round_d = RoundFirst;
        state_d = status_i.draw_ok ? StDone : StMul;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      round_q     <= RoundFirst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/hashed_counter_bounded_random.sv
// Top level of the hashed counter bounded random block.
// Depends on hcbr_pkg, hcbr_ctrl and hcbr_dp.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------
//   request  | in        | in_valid_i / in_ready_o   | sides_i [31:0]
//   result   | out       | out_valid_o / out_ready_i | value_o [31:0]
//   config   | in        | cfg_we_i                  | cfg_wdata_i [31:0]
//
// One request at a time. Each draw runs four rounds of one multiply and one
// combine on the shared 32x32 multiplier, then the bound test; a draw that fails
// the test is redrawn. A bound of 0 or 1 takes no draw and returns zero.
// The result register lets the next beat in while a result waits.
// Reset clears the seed, the draw counter and all control state.
module hashed_counter_bounded_random
  import hcbr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] sides_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] value_o
);

  hcbr_cmd_t    cmd;
  hcbr_status_t status;

  hcbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hcbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sides_i     (sides_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_o     (value_o)
  );

endmodule

FILE: hdl/hcbr_checker.sv
// Port-level checker for the hashed counter bounded random block, with its bind.
// Depends on hcbr_pkg and the top level's ports.
module hcbr_checker
  import hcbr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [DataW-1:0] sides_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DataW-1:0] value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o))
    else $error("result beat dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_trivial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (sides_i <= 32'd1) && !out_valid_o
      |-> ##3 (out_valid_o && value_o == '0))
    else $error("trivial bound did not return zero in time");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> value_o != '1)
    else $error("result out of range");

endmodule

bind hashed_counter_bounded_random hcbr_checker u_hcbr_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for hashed_counter_bounded_random: a burst driver and a stalling monitor
// check every result against a local hash-and-reject predictor across several seeds.
// Depends on hcbr_pkg and the hashed_counter_bounded_random RTL.
module tb;
  import hcbr_pkg::*;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned DrainCycles  = 60;
  localparam int unsigned PhaseItems   = 283;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldAtResult = 150;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [DataW-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [DataW-1:0] sides_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DataW-1:0] value_o;

  logic [DataW-1:0] pending_sides[$];
  logic [DataW-1:0] expected_values[$];
  logic [DataW-1:0] model_seed  = '0;
  logic [DataW-1:0] model_count = '0;
  int unsigned      error_count = 0;
  int unsigned      result_count = 0;
  int unsigned      burst_left = 0;
  int unsigned      gap_left = 0;
  int unsigned      hold_left = 0;
  logic             hold_done = 1'b0;
  int unsigned      mode_left = 0;
  int unsigned      mode_tick = 0;
  ready_mode_e      ready_mode = READY_ALWAYS;

  hashed_counter_bounded_random u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sides_i     (sides_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] hash_draw(input logic [DataW-1:0] key,
                                                 input logic [DataW-1:0] count);
    logic [DataW-1:0] a, b, c, d;
    a = (count * MixK0) ^ key;
    b = (a * MixK1) ^ (a >> MixS1) ^ a;
    c = (b * MixK2) ^ (b >> MixS2);
    d = (c * MixK3) ^ (c >> MixS3);
    return d;
  endfunction

  function automatic logic [DataW-1:0] span_mask(input logic [DataW-1:0] v);
    logic [DataW-1:0] m;
    for (int i = 0; i < DataW; i++) begin
      m[i] = |(v >> i);
    end
    return m;
  endfunction

  function automatic logic [DataW-1:0] predict_value(input logic [DataW-1:0] sides);
    logic [DataW-1:0] mask, r;
    r = '0;
    if (sides > 1) begin
      mask = span_mask(sides - 1);
      do begin
        model_count = model_count + 1;
        r = hash_draw(model_seed, model_count) & mask;
      end while (r >= sides);
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] random_sides();
    logic [DataW-1:0] s;
    case ($urandom_range(0, 9))
      0, 1:    s = $urandom_range(0, 8);
      2, 3, 4: s = $urandom >> $urandom_range(0, 31);
      5:       s = 32'd1 << $urandom_range(0, 31);
      6:       s = (32'd1 << $urandom_range(0, 31)) + 32'd1;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] exp_v,
                                 input logic [DataW-1:0] got_v);
    $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  task automatic write_seed(input logic [DataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    model_seed = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_sides.size() != 0 || in_valid_i || expected_values.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // driver: accept beats, then present the next pending item
  always @(posedge clk_i) begin
    logic take;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      take = in_valid_i && in_ready_o;
      if (take) begin
        expected_values.push_back(predict_value(sides_i));
      end
      if (!in_valid_i || take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_sides.size() > 0) begin
          in_valid_i <= 1'b1;
          sides_i    <= pending_sides.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, then pick the next ready
  always @(posedge clk_i) begin
    logic             next_ready;
    logic [DataW-1:0] exp_v;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (expected_values.size() == 0) begin
          report_mismatch("unexpected value", '0, value_o);
        end else begin
          exp_v = expected_values.pop_front();
          if (value_o !== exp_v) begin
            report_mismatch("value", exp_v, value_o);
          end
        end
      end
      mode_tick++;
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && result_count == HoldAtResult) begin
        hold_done  = 1'b1;
        hold_left  = HoldCycles;
        next_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (ready_mode)
          READY_ALWAYS:   next_ready = 1'b1;
          READY_COIN:     next_ready = 1'($urandom_range(0, 1));
          READY_SPARSE:   next_ready = ($urandom_range(0, 3) == 0);
          default:        next_ready = (mode_tick % 3 == 0);
        endcase
      end
      out_ready_i <= next_ready;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [DataW-1:0] seeds[6];
    logic [DataW-1:0] directed[20];
    seeds    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h0, 32'h0};
    seeds[4] = $urandom;
    seeds[5] = $urandom;
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8, 32'd9,
                 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000,
                 32'h0001_0001, 32'd1, 32'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      write_seed(seeds[p]);
      if (p == 0) begin
        foreach (directed[i]) pending_sides.push_back(directed[i]);
      end
      for (int i = 0; i < PhaseItems; i++) begin
        pending_sides.push_back(random_sides());
      end
      wait_drained();
    end
    if (expected_values.size() != 0) begin
      report_mismatch("leftover expectations", '0, expected_values.size());
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
